// ----- rtl/mandelbrot_membership_test_core_defines.svh -----
// ----------------------------------------------------------------------------
// Mandelbrot membership test - assertion macros
// Concurrent checks on the core clock, held off while reset is low or checked in reset too.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_MEMBERSHIP_TEST_CORE_DEFINES_SVH
`define MANDELBROT_MEMBERSHIP_TEST_CORE_DEFINES_SVH

// check a property on the core clock outside reset
`define MBT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check a property on the core clock, reset included
`define MBT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/mbt_pkg.sv -----
// ----------------------------------------------------------------------------
// Mandelbrot membership test - package
// Widths, register map and the status group passed between cells and control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mbt_pkg;

  localparam int unsigned FracBitsDef = 24;
  localparam int unsigned CWidth      = 32;
  localparam int unsigned IterW       = 10;
  localparam int unsigned CntW        = IterW + 1;
  localparam logic [IterW-1:0] MaxIterRst = 10'd100;

  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CfgAddrW = 3;
  localparam logic [CfgAddrW-3:0] RegMaxIter = 1'b0;

  // z parts stay below 10 in magnitude: four integer bits and a sign
  function automatic int unsigned z_width(int unsigned fb);
    return fb + 5;
  endfunction

  // scaled products stay below 100 in magnitude
  function automatic int unsigned prod_width(int unsigned fb);
    return fb + 9;
  endfunction

  function automatic int unsigned sum_width(int unsigned fb);
    int unsigned pw;
    pw = prod_width(fb);
    return ((pw > CWidth) ? pw : CWidth) + 2;
  endfunction

  typedef struct packed {
    logic esc_sq;
    logic esc_big;
  } upd_flags_t;

endpackage

// ----- rtl/mbt_sq_cell.sv -----
// ----------------------------------------------------------------------------
// Mandelbrot membership test - square cell
// Forms the three scaled products of z and hands them to the update cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbt_sq_cell #(
  parameter  int unsigned FRAC_BITS = mbt_pkg::FracBitsDef,
  localparam int unsigned ZW        = mbt_pkg::z_width(FRAC_BITS),
  localparam int unsigned PW        = mbt_pkg::prod_width(FRAC_BITS)
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [ZW-1:0] z_re_i,
  input  logic signed [ZW-1:0] z_im_i,
  output logic signed [PW-1:0] rr_o,
  output logic signed [PW-1:0] ii_o,
  output logic signed [PW-1:0] ri_o
);
  import mbt_pkg::*;

  logic signed [2*ZW-1:0] p_rr, p_ii, p_ri;
  logic signed [2*ZW-1:0] s_rr, s_ii, s_ri;
  logic signed [PW-1:0]   rr_q, ii_q, ri_q;

  assign p_rr = z_re_i * z_re_i;
  assign p_ii = z_im_i * z_im_i;
  assign p_ri = z_re_i * z_im_i;

  // floor toward minus infinity
  assign s_rr = p_rr >>> FRAC_BITS;
  assign s_ii = p_ii >>> FRAC_BITS;
  assign s_ri = p_ri >>> FRAC_BITS;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rr_q <= s_rr[PW-1:0];
      ii_q <= s_ii[PW-1:0];
      ri_q <= s_ri[PW-1:0];
    end
  end

  assign rr_o = rr_q;
  assign ii_o = ii_q;
  assign ri_o = ri_q;

endmodule

// ----- rtl/mbt_upd_cell.sv -----
// ----------------------------------------------------------------------------
// Mandelbrot membership test - update cell
// Holds c and z, forms the next z from the products and flags an escape.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbt_upd_cell #(
  parameter  int unsigned FRAC_BITS = mbt_pkg::FracBitsDef,
  localparam int unsigned ZW        = mbt_pkg::z_width(FRAC_BITS),
  localparam int unsigned PW        = mbt_pkg::prod_width(FRAC_BITS),
  localparam int unsigned SW        = mbt_pkg::sum_width(FRAC_BITS)
) (
  input  logic                               clk_i,
  input  logic                               load_i,
  input  logic                               en_i,
  input  logic signed [mbt_pkg::CWidth-1:0]  c_re_i,
  input  logic signed [mbt_pkg::CWidth-1:0]  c_im_i,
  input  logic signed [PW-1:0]               rr_i,
  input  logic signed [PW-1:0]               ii_i,
  input  logic signed [PW-1:0]               ri_i,
  output logic signed [ZW-1:0]               z_re_o,
  output logic signed [ZW-1:0]               z_im_o,
  output mbt_pkg::upd_flags_t                flags_o
);
  import mbt_pkg::*;

  localparam int unsigned MW = PW + 1;
  localparam logic signed [SW-1:0] LimPart = SW'(64'd10 << FRAC_BITS);
  localparam logic signed [SW-1:0] LimNeg  = -LimPart;
  localparam logic [MW-1:0]        LimSq   = MW'(64'd100 << FRAC_BITS);

  logic signed [CWidth-1:0] c_re_q, c_im_q;
  logic signed [ZW-1:0]     z_re_q, z_im_q;
  logic signed [SW-1:0]     rr_x, ii_x, ri_x, cr_x, ci_x;
  logic signed [SW-1:0]     zr_w, zi_w;
  logic [MW-1:0]            mag_sq;

  assign rr_x = {{(SW-PW){rr_i[PW-1]}}, rr_i};
  assign ii_x = {{(SW-PW){ii_i[PW-1]}}, ii_i};
  assign ri_x = {{(SW-PW){ri_i[PW-1]}}, ri_i};
  assign cr_x = {{(SW-CWidth){c_re_q[CWidth-1]}}, c_re_q};
  assign ci_x = {{(SW-CWidth){c_im_q[CWidth-1]}}, c_im_q};

  assign zr_w = rr_x - ii_x + cr_x;
  assign zi_w = (ri_x <<< 1) + ci_x;

  // squares of the current z are nonnegative
  assign mag_sq = {1'b0, rr_i} + {1'b0, ii_i};

  assign flags_o.esc_sq  = (mag_sq >= LimSq);
  assign flags_o.esc_big = (zr_w >= LimPart) || (zr_w <= LimNeg) ||
                           (zi_w >= LimPart) || (zi_w <= LimNeg);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      c_re_q <= c_re_i;
      c_im_q <= c_im_i;
      z_re_q <= '0;
      z_im_q <= '0;
    end else if (en_i) begin
      z_re_q <= zr_w[ZW-1:0];
      z_im_q <= zi_w[ZW-1:0];
    end
  end

  assign z_re_o = z_re_q;
  assign z_im_o = z_im_q;

endmodule

// ----- rtl/mandelbrot_membership_test_core.sv -----
// ----------------------------------------------------------------------------
// Mandelbrot membership test - core
// Iterates z = z*z + c for one point and reports whether it stays bounded.
// ----------------------------------------------------------------------------
// A point c is taken when the core is idle and iterated in a ring of two
// cells: the square cell registers the three scaled products of z, and the
// update cell forms the next z and tests for escape. Each iteration passes
// through both cells in turn; a point that does not escape runs until the
// iteration count reaches max_iter + 1, and an escaping point finishes early.
// The next point is taken as soon as the result is in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mandelbrot_membership_test_core_defines.svh"

module mandelbrot_membership_test_core #(
  parameter int unsigned FRAC_BITS = mbt_pkg::FracBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [mbt_pkg::CWidth-1:0]   c_re_i,
  input  logic signed [mbt_pkg::CWidth-1:0]   c_im_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                inside_res_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mbt_pkg::CfgAddrW-1:0]        paddr,
  input  logic [mbt_pkg::CfgDataW-1:0]        pwdata,
  output logic [mbt_pkg::CfgDataW-1:0]        prdata,
  output logic                                pready
);
  import mbt_pkg::*;

  localparam int unsigned ZW = z_width(FRAC_BITS);
  localparam int unsigned PW = prod_width(FRAC_BITS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SQ,
    S_UPD
  } state_e;

  state_e               state_q;
  logic [CntW-1:0]      cnt_q;
  logic                 out_valid_q;
  logic                 res_q;
  logic [IterW-1:0]     max_iter_q;

  logic                 accept_in;
  logic                 out_free;
  logic                 last_iter;
  logic                 finish;
  logic                 cfg_wr;
  logic [CntW-1:0]      iter_total;
  logic [CfgAddrW-3:0]  reg_idx;

  logic signed [ZW-1:0] z_re, z_im;
  logic signed [PW-1:0] rr, ii, ri;
  upd_flags_t           flags;

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept_in   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign iter_total  = {1'b0, max_iter_q} + CntW'(1);
  assign last_iter   = (cnt_q == iter_total);
  assign finish      = flags.esc_sq || last_iter || flags.esc_big;

  mbt_sq_cell #(
    .FRAC_BITS (FRAC_BITS)
  ) u_sq_cell (
    .clk_i  (clk_i),
    .en_i   (state_q == S_SQ),
    .z_re_i (z_re),
    .z_im_i (z_im),
    .rr_o   (rr),
    .ii_o   (ii),
    .ri_o   (ri)
  );

  mbt_upd_cell #(
    .FRAC_BITS (FRAC_BITS)
  ) u_upd_cell (
    .clk_i   (clk_i),
    .load_i  (accept_in),
    .en_i    ((state_q == S_UPD) && !finish),
    .c_re_i  (c_re_i),
    .c_im_i  (c_im_i),
    .rr_i    (rr),
    .ii_i    (ii),
    .ri_i    (ri),
    .z_re_o  (z_re),
    .z_im_o  (z_im),
    .flags_o (flags)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      res_q       <= 1'b0;
    end else begin
      if ((state_q == S_UPD) && finish && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept_in) begin
            cnt_q   <= '0;
            state_q <= S_SQ;
          end
        end
        S_SQ: begin
          state_q <= S_UPD;
        end
        S_UPD: begin
          if (finish) begin
            if (out_free) begin
              res_q   <= !flags.esc_sq && last_iter;
              state_q <= S_IDLE;
            end
          end else begin
            cnt_q   <= cnt_q + CntW'(1);
            state_q <= S_SQ;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign inside_res_o = res_q;

  assign reg_idx = paddr[CfgAddrW-1:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q <= MaxIterRst;
    end else if (cfg_wr && (reg_idx == RegMaxIter)) begin
      max_iter_q <= pwdata[IterW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == RegMaxIter) begin
      prdata = CfgDataW'(max_iter_q);
    end
  end

  `MBT_ASSERT(a_out_from_upd, $rose(out_valid_q) |-> $past(state_q == S_UPD), "result without update step")
  `MBT_ASSERT(a_accept_starts, accept_in |=> (state_q == S_SQ) && (cnt_q == '0), "item not started")
  `MBT_ASSERT(a_bounded_full, ($rose(out_valid_q) && res_q) |-> $past(cnt_q == iter_total), "bounded result before last iteration")
  `MBT_ASSERT_ALWAYS(a_stall_busy, in_stall_o == (state_q != S_IDLE), "stall out of step with busy")

endmodule

// ----- tb/mandelbrot_membership_test_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot membership test core - testbench
// Drives points c through the valid/stall input with random gaps and checks
// each inside flag against a fixed-point escape predictor. The iteration
// limit is set over the APB port between phases, the extremes included.
// ----------------------------------------------------------------------------

class membership_board;
  logic [mbt_pkg::IterW-1:0] iter_lim;
  bit                        inside_q[$];
  int unsigned               mismatches;

  function new();
    iter_lim   = mbt_pkg::MaxIterRst;
    mismatches = 0;
  endfunction

  function void note_write(logic [mbt_pkg::CfgAddrW-1:0] addr,
                           logic [mbt_pkg::CfgDataW-1:0] data);
    if (addr[mbt_pkg::CfgAddrW-1:2] == mbt_pkg::RegMaxIter) begin
      iter_lim = data[mbt_pkg::IterW-1:0];
    end
  endfunction

  function bit stays_inside(logic signed [31:0] re, logic signed [31:0] im);
    longint      cr, ci, zr, zi, nr, ni, part_lim, sq_lim;
    int unsigned rounds;
    bit          gone;
    cr       = re;
    ci       = im;
    zr       = 0;
    zi       = 0;
    gone     = 1'b0;
    part_lim = longint'(10) <<< mbt_pkg::FracBitsDef;
    sq_lim   = longint'(100) <<< mbt_pkg::FracBitsDef;
    rounds   = int'(iter_lim) + 1;
    for (int unsigned k = 0; k < rounds && !gone; k++) begin
      nr = ((zr * zr) >>> mbt_pkg::FracBitsDef) - ((zi * zi) >>> mbt_pkg::FracBitsDef) + cr;
      ni = 2 * ((zr * zi) >>> mbt_pkg::FracBitsDef) + ci;
      zr = nr;
      zi = ni;
      if (zr >= part_lim || -zr >= part_lim || zi >= part_lim || -zi >= part_lim) begin
        gone = 1'b1;
      end else if (((zr * zr) >>> mbt_pkg::FracBitsDef) +
                   ((zi * zi) >>> mbt_pkg::FracBitsDef) >= sq_lim) begin
        gone = 1'b1;
      end
    end
    return !gone;
  endfunction

  function void take_point(logic signed [31:0] re, logic signed [31:0] im);
    inside_q.push_back(stays_inside(re, im));
  endfunction

  function void check_flag(logic got);
    bit want;
    if (inside_q.size() == 0) begin
      $display("%0t: result with no point waiting, expected none, actual %b", $time, got);
      mismatches++;
    end else begin
      want = inside_q.pop_front();
      if (got !== want) begin
        $display("%0t: inside flag mismatch, expected %b, actual %b", $time, want, got);
        mismatches++;
      end
    end
  endfunction

  function int unsigned pending();
    return inside_q.size();
  endfunction
endclass

module mandelbrot_membership_test_core_test;

  localparam int One = 1 << mbt_pkg::FracBitsDef;
  localparam logic [mbt_pkg::CfgAddrW-1:0] AddrMaxIter = {mbt_pkg::RegMaxIter, 2'b00};
  localparam logic [mbt_pkg::CfgAddrW-1:0] AddrNoReg   = {~mbt_pkg::RegMaxIter, 2'b00};

  logic                                clk_i = 1'b0;
  logic                                rst_ni;
  logic                                in_valid_i;
  logic                                in_stall_o;
  logic signed [mbt_pkg::CWidth-1:0]   c_re_i;
  logic signed [mbt_pkg::CWidth-1:0]   c_im_i;
  logic                                out_valid_o;
  logic                                out_stall_i;
  logic                                inside_res_o;
  logic                                psel;
  logic                                penable;
  logic                                pwrite;
  logic [mbt_pkg::CfgAddrW-1:0]        paddr;
  logic [mbt_pkg::CfgDataW-1:0]        pwdata;
  logic [mbt_pkg::CfgDataW-1:0]        prdata;
  logic                                pready;

  membership_board board;
  bit              gaps_on;
  int unsigned     long_hold;

  mandelbrot_membership_test_core dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic write_reg(input logic [mbt_pkg::CfgAddrW-1:0] addr,
                           input logic [mbt_pkg::CfgDataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.note_write(addr, data);
  endtask

  task automatic offer_point(input logic signed [31:0] re, input logic signed [31:0] im);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    c_re_i     <= re;
    c_im_i     <= im;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    board.take_point(re, im);
  endtask

  // drop valid and wait for every outstanding flag
  task automatic settle();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic run_phase(input int unsigned iter, input int unsigned count, input bit stray);
    logic [mbt_pkg::CfgDataW-1:0] word;
    logic signed [31:0]           re, im;
    int unsigned                  pick;
    settle();
    word = $urandom;
    word[mbt_pkg::IterW-1:0] = iter[mbt_pkg::IterW-1:0];
    write_reg(AddrMaxIter, word);
    if (stray) begin
      word = $urandom;
      write_reg(AddrNoReg, word);
    end
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        re = $urandom_range(0, 3 * One) - (9 * One / 4);
        im = $urandom_range(0, 3 * One) - (3 * One / 2);
      end else if (pick < 80) begin
        case ($urandom_range(0, 3))
          0: begin
            re = -3 * One / 4;
            im = 0;
          end
          1: begin
            re = One / 4;
            im = 0;
          end
          2: begin
            re = -5 * One / 4;
            im = 0;
          end
          default: begin
            re = -One / 10;
            im = 13 * One / 20;
          end
        endcase
        re = re + $urandom_range(0, 1 << 17) - (1 << 16);
        im = im + $urandom_range(0, 1 << 17) - (1 << 16);
      end else if (pick < 90) begin
        re = $signed($urandom) >>> 3;
        im = $signed($urandom) >>> 3;
      end else begin
        re = $urandom;
        im = $urandom;
      end
      offer_point(re, im);
    end
  endtask

  initial begin : result_side
    int unsigned hold;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (long_hold != 0) begin
        hold      = long_hold;
        long_hold = 0;
      end else begin
        hold = gaps_on ? $urandom_range(0, 9) : 0;
      end
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      board.check_flag(inside_res_o);
    end
  end

  initial begin : stimulus
    int unsigned sent, iter, count, pick;
    board       = new();
    gaps_on     = 1'b1;
    long_hold   = 0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    c_re_i      <= '0;
    c_im_i      <= '0;
    out_stall_i <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset iteration limit, edge points
    offer_point(0, 0);
    offer_point(32'sh8000_0000, 32'sh8000_0000);
    offer_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    offer_point(32'sh8000_0000, 0);
    offer_point(0, 32'sh7FFF_FFFF);
    offer_point(-2 * One, 0);
    offer_point(One / 4, 0);
    offer_point(One / 4 + One / 100, 0);
    offer_point(-One, 0);
    offer_point(One, 0);
    offer_point(0, One);
    offer_point(0, -One);
    offer_point(-3 * One / 4, One / 10);
    offer_point(10 * One, 0);
    offer_point(-10 * One + 1, 0);
    offer_point(0, -10 * One);
    offer_point(6 * One, 8 * One);
    offer_point(6 * One, 8 * One - 1);
    offer_point(7 * One + 7 * One / 100, 7 * One + 7 * One / 100);
    offer_point(-One / 10, 13 * One / 20);

    run_phase(0, 40, 1'b0);
    run_phase((1 << mbt_pkg::IterW) - 1, 8, 1'b1);

    // hold the result side long enough for the core to back up
    long_hold = 2500;
    run_phase(20, 40, 1'b0);

    gaps_on = 1'b0;
    run_phase(1, 40, 1'b0);
    gaps_on = 1'b1;

    sent = 0;
    while (sent < 1750) begin
      pick  = $urandom_range(0, 99);
      count = $urandom_range(30, 120);
      if (pick < 70) begin
        iter = $urandom_range(0, 31);
      end else if (pick < 95) begin
        iter = $urandom_range(32, 127);
      end else begin
        iter  = (1 << mbt_pkg::IterW) - 1;
        count = 3;
      end
      gaps_on = ($urandom_range(0, 3) != 0);
      run_phase(iter, count, $urandom_range(0, 9) == 0);
      sent += count;
    end

    settle();
    repeat (2 * (1 << mbt_pkg::IterW) + 8) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #40_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
